// ===== sv/shamh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shamh_pkg
// Shared types, round constants and initial hash values for the SHA-256
// message hasher.
// ----------------------------------------------------------------------------
package shamh_pkg;

   typedef logic [31:0] word_type;
   typedef word_type [7:0] state_vec_type;
   typedef word_type [15:0] sched_type;

   localparam logic [7:0] MARKER_BYTE = 8'h80;

   function automatic word_type ror32(input word_type v, input int s);
      ror32 = (v >> s) | (v << (32 - s));
   endfunction

   function automatic word_type initial_h(input logic [2:0] idx);
      word_type r;
      unique case (idx)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic word_type round_k(input logic [5:0] idx);
      word_type r;
      unique case (idx)
         6'd0:  r = 32'h428a2f98;
         6'd1:  r = 32'h71374491;
         6'd2:  r = 32'hb5c0fbcf;
         6'd3:  r = 32'he9b5dba5;
         6'd4:  r = 32'h3956c25b;
         6'd5:  r = 32'h59f111f1;
         6'd6:  r = 32'h923f82a4;
         6'd7:  r = 32'hab1c5ed5;
         6'd8:  r = 32'hd807aa98;
         6'd9:  r = 32'h12835b01;
         6'd10: r = 32'h243185be;
         6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74;
         6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7;
         6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1;
         6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6;
         6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f;
         6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc;
         6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152;
         6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8;
         6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3;
         6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351;
         6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85;
         6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc;
         6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354;
         6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e;
         6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1;
         6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70;
         6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819;
         6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585;
         6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116;
         6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c;
         6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3;
         6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f;
         6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee;
         6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814;
         6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa;
         6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7;
         default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== sv/shamh_round.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// shamh_round
// One SHA-256 compression round and one message schedule extension step.
// ----------------------------------------------------------------------------
module shamh_round
   import shamh_pkg::*;
(
   input  wire state_vec_type v_i,
   input  wire sched_type     sched_i,
   input  wire word_type      k_i,
   output state_vec_type      v_o,
   output word_type           w_next_o
);

   word_type a, e, t1, t2, bs0, bs1, ch, maj, ss0, ss1;

   assign a   = v_i[0];
   assign e   = v_i[4];
   assign bs1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
   assign bs0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
   assign ch  = (e & v_i[5]) ^ (~e & v_i[6]);
   assign maj = (a & v_i[1]) ^ (a & v_i[2]) ^ (v_i[1] & v_i[2]);
   assign t1  = v_i[7] + bs1 + ch + k_i + sched_i[0];
   assign t2  = bs0 + maj;

   assign v_o[0] = t1 + t2;
   assign v_o[1] = v_i[0];
   assign v_o[2] = v_i[1];
   assign v_o[3] = v_i[2];
   assign v_o[4] = v_i[3] + t1;
   assign v_o[5] = v_i[4];
   assign v_o[6] = v_i[5];
   assign v_o[7] = v_i[6];

   // sched_i[j] holds w[t+j]
   assign ss0 = ror32(sched_i[1], 7) ^ ror32(sched_i[1], 18) ^ (sched_i[1] >> 3);
   assign ss1 = ror32(sched_i[14], 17) ^ ror32(sched_i[14], 19) ^ (sched_i[14] >> 10);
   assign w_next_o = ss1 + sched_i[9] + ss0 + sched_i[0];

endmodule
`default_nettype wire

// ===== sv/sha256_message_hasher_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hasher_top
// SHA-256 hasher: bytes in, digest words out. Block words and hash words
// live in two small synchronous RAMs.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_stall  | req_action, req_data_byte
// rsp     | out       | rsp_valid/rsp_stall  | rsp_digest_word, rsp_last_word
//
// Absorb request: taken in idle; a full block then runs the RAM load, 64
// rounds and the hash writeback on the one-round-per-cycle datapath.
// Finish: padding words from the current word index to the block end, then
// the block; with 56 or more bytes buffered a second padded block follows;
// then each digest word is read, registered and held until rsp_stall drops.
// Reset is synchronous; hash RAM reads as the initial values until first
// writeback, so no clearing pass. Requests are held off while busy; rsp_stall
// holds the digest word register.
module sha256_message_hasher_top
   import shamh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_action,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [31:0]      rsp_digest_word,
   output logic             rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_WB, ST_OUT_RD, ST_OUT_LD, ST_OUT_WAIT
   } state_type;

   state_type     state_ff, state_in;
   logic [63:0]   count_ff, count_in;
   logic [23:0]   word_ff, word_in;
   logic          finishing_ff, finishing_in;
   logic          second_ff, second_in;
   logic          marker_ff, marker_in;
   logic          fresh_ff, fresh_in;
   logic [3:0]    pad_idx_ff, pad_idx_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic [5:0]    rnd_ff, rnd_in;
   logic [2:0]    out_idx_ff, out_idx_in;
   state_vec_type v_ff, v_in, v_next;
   sched_type     sched_ff, sched_in;
   word_type      w_next;
   logic          rsp_valid_ff, rsp_valid_in;
   word_type      rsp_word_ff, rsp_word_in;
   logic          rsp_last_ff, rsp_last_in;

   word_type      blk_mem [16];
   logic          blk_we;
   logic [3:0]    blk_waddr, blk_raddr;
   word_type      blk_wdata, blk_rdata_ff;

   word_type      hash_mem [8];
   logic          hash_we;
   logic [2:0]    hash_waddr, hash_raddr, hash_raddr_ff;
   word_type      hash_wdata, hash_rdata_ff, hdata;

   word_type      marker_word;
   logic [2:0]    cnt_m1;

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;

   assign hdata  = fresh_ff ? initial_h(hash_raddr_ff) : hash_rdata_ff;
   assign cnt_m1 = 3'(cnt_ff - 5'd1);

   shamh_round u_round (
      .v_i      (v_ff),
      .sched_i  (sched_ff),
      .k_i      (round_k(rnd_ff)),
      .v_o      (v_next),
      .w_next_o (w_next)
   );

   always_comb begin
      case (count_ff[4:3])
         2'd0:    marker_word = {MARKER_BYTE, 24'h0};
         2'd1:    marker_word = {word_ff[7:0], MARKER_BYTE, 16'h0};
         2'd2:    marker_word = {word_ff[15:0], MARKER_BYTE, 8'h0};
         default: marker_word = {word_ff[23:0], MARKER_BYTE};
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      word_in      = word_ff;
      finishing_in = finishing_ff;
      second_in    = second_ff;
      marker_in    = marker_ff;
      fresh_in     = fresh_ff;
      pad_idx_in   = pad_idx_ff;
      cnt_in       = cnt_ff;
      rnd_in       = rnd_ff;
      out_idx_in   = out_idx_ff;
      v_in         = v_ff;
      sched_in     = sched_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      blk_we       = 1'b0;
      blk_waddr    = pad_idx_ff;
      blk_wdata    = '0;
      blk_raddr    = cnt_ff[3:0];
      hash_we      = 1'b0;
      hash_waddr   = cnt_m1;
      hash_wdata   = hdata + v_ff[cnt_m1];
      hash_raddr   = cnt_ff[2:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!req_action) begin
                  count_in = count_ff + 64'd8;
                  word_in  = {word_ff[15:0], req_data_byte};
                  if (count_ff[4:3] == 2'd3) begin
                     blk_we    = 1'b1;
                     blk_waddr = count_ff[8:5];
                     blk_wdata = {word_ff, req_data_byte};
                  end
                  if (count_ff[8:3] == 6'd63) begin
                     finishing_in = 1'b0;
                     cnt_in       = '0;
                     state_in     = ST_LOAD;
                  end
               end else begin
                  finishing_in = 1'b1;
                  marker_in    = 1'b1;
                  second_in    = (count_ff[8:6] == 3'b111);
                  pad_idx_in   = count_ff[8:5];
                  state_in     = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            blk_we = 1'b1;
            if (marker_ff) begin
               blk_wdata = marker_word;
            end else if (!second_ff && pad_idx_ff == 4'd14) begin
               blk_wdata = count_ff[63:32];
            end else if (!second_ff && pad_idx_ff == 4'd15) begin
               blk_wdata = count_ff[31:0];
            end
            marker_in  = 1'b0;
            pad_idx_in = pad_idx_ff + 4'd1;
            if (pad_idx_ff == 4'd15) begin
               cnt_in   = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (cnt_ff != 5'd0) begin
               sched_in = {blk_rdata_ff, sched_ff[15:1]};
            end
            if (cnt_ff != 5'd0 && cnt_ff <= 5'd8) begin
               v_in[cnt_m1] = hdata;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               rnd_in   = '0;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in     = v_next;
            sched_in = {w_next, sched_ff[15:1]};
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               cnt_in   = '0;
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            hash_we = (cnt_ff != 5'd0);
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd8) begin
               fresh_in = 1'b0;
               if (!finishing_ff) begin
                  state_in = ST_IDLE;
               end else if (second_ff) begin
                  second_in  = 1'b0;
                  pad_idx_in = '0;
                  state_in   = ST_PAD;
               end else begin
                  out_idx_in = '0;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         ST_OUT_RD: begin
            hash_raddr = out_idx_ff;
            state_in   = ST_OUT_LD;
         end
         ST_OUT_LD: begin
            rsp_word_in  = hdata;
            rsp_last_in  = (out_idx_ff == 3'd7);
            rsp_valid_in = 1'b1;
            state_in     = ST_OUT_WAIT;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (out_idx_ff == 3'd7) begin
                  count_in     = '0;
                  fresh_in     = 1'b1;
                  finishing_in = 1'b0;
                  state_in     = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
                  state_in   = ST_OUT_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         finishing_ff <= 1'b0;
         second_ff    <= 1'b0;
         marker_ff    <= 1'b0;
         fresh_ff     <= 1'b1;
         pad_idx_ff   <= '0;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         finishing_ff <= finishing_in;
         second_ff    <= second_in;
         marker_ff    <= marker_in;
         fresh_ff     <= fresh_in;
         pad_idx_ff   <= pad_idx_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      word_ff     <= word_in;
      v_ff        <= v_in;
      sched_ff    <= sched_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      blk_rdata_ff <= blk_mem[blk_raddr];
   end

   always_ff @(posedge clock) begin
      if (hash_we) begin
         hash_mem[hash_waddr] <= hash_wdata;
      end
      hash_rdata_ff <= hash_mem[hash_raddr];
      hash_raddr_ff <= hash_raddr;
   end

`ifndef ASSERT_OFF
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> req_stall)
      else $error("request taken while digest word pending");

   a_rounds_to_wb: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND && rnd_ff == 6'd63) |=> (state_ff == ST_WB))
      else $error("writeback did not follow final round");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && rsp_last_ff) |=> (count_ff == 64'd0 && fresh_ff))
      else $error("message state not cleared after last digest word");

   a_pad_only_finishing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> finishing_ff)
      else $error("padding outside finish");
`endif

endmodule
`default_nettype wire
